// ===== rtl/tmi_pkg.sv =====
// Package for the tape machine interpreter.
// Holds the action and result codes and the UTF-8 token byte patterns.
// No dependencies.
package tmi_pkg;

   typedef enum logic [1:0] {
      ACT_APPEND  = 2'd0,
      ACT_CLEAR   = 2'd1,
      ACT_RESTART = 2'd2,
      ACT_RESUME  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      KIND_ACK        = 4'd0,
      KIND_OUTPUT     = 4'd1,
      KIND_NEED_INPUT = 4'd2,
      KIND_HALTED     = 4'd3,
      KIND_OPEN_ERR   = 4'd4,
      KIND_CLOSE_ERR  = 4'd5,
      KIND_BUDGET     = 4'd6,
      KIND_OVERFLOW   = 4'd7,
      KIND_FULL       = 4'd8
   } kind_type;

   localparam int unsigned POS_OUT_W = 13;
   localparam int unsigned WIN_LEN   = 6;

   localparam logic [23:0] TK_RIGHT = 24'hE597AF;
   localparam logic [23:0] TK_LEFT  = 24'hE593A6;
   localparam logic [23:0] TK_INC   = 24'hE5958A;
   localparam logic [23:0] TK_DEC   = 24'hE9BD81;
   localparam logic [47:0] TK_OUT   = 48'hE58EBBE4BA86;
   localparam logic [23:0] TK_IN    = 24'hEFBC9F;
   localparam logic [23:0] TK_OPEN  = 24'hEFBC81;
   localparam logic [23:0] TK_CLOSE = 24'hE299A1;

   localparam logic [7:0] EOF_BYTE = 8'hFF;

endpackage

// ===== rtl/tape_machine_interpreter.sv =====
// Tape machine interpreter top level: program store, tape and loop stack memories
// with the sequencer that runs tokens out of them.
// Depends on tmi_pkg.
//
// Usage: items arrive on the req_ channel (action, program byte, input byte, eof);
// each item yields exactly one transfer on the rsp_ channel (kind, out_byte,
// program_position). csr_ writes the step budget and are always taken.
// Append, clear and restart go from the idle state straight to the emit state. A
// resume runs the program: each examined position is fetched as a 6-byte window,
// one byte a cycle from the single-port program store, then decoded, and a forward
// bracket scan fetches and decodes each scanned position the same way. The steps
// of a resume are bounded by the step budget; scanned positions are not counted.
// One item is in work at a time; the next item is taken while a finished result
// waits in the output register, and the sequencer holds in its emit state when the
// receiver stalls with a result already waiting.
// Reset, clear and restart run a clearing pass over all TAPE_DEPTH tape cells,
// one cell a cycle, during which no item is taken.
module tape_machine_interpreter #(
   parameter int unsigned PROGRAM_DEPTH = 4096,
   parameter int unsigned TAPE_DEPTH    = 32768,
   parameter int unsigned STACK_DEPTH   = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_program_byte,
   input  logic [7:0]  req_input_byte,
   input  logic        req_input_eof,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [12:0] rsp_program_position,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_step_budget
);

   localparam int unsigned AW  = $clog2(PROGRAM_DEPTH);
   localparam int unsigned LW  = $clog2(PROGRAM_DEPTH + 1);
   localparam int unsigned TW  = $clog2(TAPE_DEPTH);
   localparam int unsigned SW  = $clog2(STACK_DEPTH);
   localparam int unsigned SCW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned WIN_LEN_C = tmi_pkg::WIN_LEN;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_CLEAR = 8'b0000_0010,
      ST_CHECK = 8'b0000_0100,
      ST_FETCH = 8'b0000_1000,
      ST_DEC   = 8'b0001_0000,
      ST_SCHK  = 8'b0010_0000,
      ST_SDEC  = 8'b0100_0000,
      ST_EMIT  = 8'b1000_0000
   } state_type;

   logic [7:0]  prog_mem [PROGRAM_DEPTH];
   logic [7:0]  tape_mem [TAPE_DEPTH];
   logic [AW-1:0] stk_mem [STACK_DEPTH];

   state_type   state_ff, state_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic [LW-1:0] fp_ff, fp_in;
   logic [LW-1:0] depth_ff, depth_in;
   logic [TW-1:0] dp_ff, dp_in;
   logic [TW-1:0] clr_ff, clr_in;
   logic [SCW-1:0] sc_ff, sc_in;
   logic        await_ff, await_in;
   logic        scan_ff, scan_in;
   logic        clrpend_ff, clrpend_in;
   logic [15:0] budget_ff;
   logic [15:0] steps_ff, steps_in;
   logic [2:0]  fk_ff, fk_in;
   logic [7:0]  win_ff [WIN_LEN_C];
   tmi_pkg::kind_type kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic        rsp_valid_ff;
   logic [3:0]  rsp_kind_ff;
   logic [7:0]  rsp_byte_ff;
   logic [12:0] rsp_pos_ff;

   logic [7:0]  prog_q;
   logic [7:0]  tape_q;
   logic [AW-1:0] stk_q;

   logic        prog_we;
   logic [AW-1:0] prog_wa;
   logic        prog_re;
   logic [AW-1:0] prog_ra;
   logic        tape_we;
   logic [TW-1:0] tape_wa;
   logic [7:0]  tape_wd;
   logic        rd_first;
   logic        stk_we;
   logic [AW-1:0] stk_wd;

   logic        req_xfer;
   logic        slot_free;
   logic [LW-1:0] rem;
   logic        ge3, ge6;
   logic [23:0] w3;
   logic [47:0] w6;
   logic [15:0] budget_eff;
   logic [TW-1:0] dp_next, dp_prev;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = rsp_kind_ff;
   assign rsp_out_byte         = rsp_byte_ff;
   assign rsp_program_position = rsp_pos_ff;

   assign rem = len_ff - fp_ff;
   assign ge3 = (fp_ff < len_ff) && (rem >= LW'(3));
   assign ge6 = (fp_ff < len_ff) && (rem >= LW'(6));
   assign w3  = {win_ff[0], win_ff[1], win_ff[2]};
   assign w6  = {win_ff[0], win_ff[1], win_ff[2], win_ff[3], win_ff[4], win_ff[5]};
   assign budget_eff = (budget_ff == 16'd0) ? 16'd1 : budget_ff;
   assign dp_next = (dp_ff == TW'(TAPE_DEPTH - 1)) ? '0 : dp_ff + 1'b1;
   assign dp_prev = (dp_ff == '0) ? TW'(TAPE_DEPTH - 1) : dp_ff - 1'b1;

   assign prog_re  = (state_ff == ST_FETCH) && (fk_ff < 3'(WIN_LEN_C));
   assign prog_ra  = AW'(fp_ff + LW'(fk_ff));
   assign rd_first = (state_ff == ST_FETCH) && (fk_ff == 3'd0);

   // memories
   always_ff @(posedge clock) begin
      if (prog_we) begin
         prog_mem[prog_wa] <= req_program_byte;
      end
      if (prog_re) begin
         prog_q <= prog_mem[prog_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (tape_we) begin
         tape_mem[tape_wa] <= tape_wd;
      end
      if (rd_first) begin
         tape_q <= tape_mem[dp_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[sc_ff[SW-1:0]] <= stk_wd;
      end
      if (rd_first) begin
         stk_q <= stk_mem[SW'(sc_ff - 1'b1)];
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_FETCH) && (fk_ff != 3'd0)) begin
         win_ff[fk_ff - 3'd1] <= prog_q;
      end
   end

   always_comb begin
      state_in   = state_ff;
      len_in     = len_ff;
      pos_in     = pos_ff;
      fp_in      = fp_ff;
      depth_in   = depth_ff;
      dp_in      = dp_ff;
      clr_in     = clr_ff;
      sc_in      = sc_ff;
      await_in   = await_ff;
      scan_in    = scan_ff;
      clrpend_in = clrpend_ff;
      steps_in   = steps_ff;
      fk_in      = fk_ff;
      kind_in    = kind_ff;
      byte_in    = byte_ff;
      prog_we    = 1'b0;
      prog_wa    = len_ff[AW-1:0];
      tape_we    = 1'b0;
      tape_wa    = dp_ff;
      tape_wd    = 8'd0;
      stk_we     = 1'b0;
      stk_wd     = pos_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               kind_in  = tmi_pkg::KIND_ACK;
               byte_in  = 8'd0;
               state_in = ST_EMIT;
               unique case (tmi_pkg::action_type'(req_action))
                  tmi_pkg::ACT_APPEND: begin
                     if (len_ff >= LW'(PROGRAM_DEPTH)) begin
                        kind_in = tmi_pkg::KIND_FULL;
                     end else begin
                        prog_we = 1'b1;
                        len_in  = len_ff + 1'b1;
                     end
                  end
                  tmi_pkg::ACT_CLEAR, tmi_pkg::ACT_RESTART: begin
                     if (req_action == tmi_pkg::ACT_CLEAR) begin
                        len_in = '0;
                     end
                     pos_in     = '0;
                     dp_in      = '0;
                     sc_in      = '0;
                     await_in   = 1'b0;
                     clrpend_in = 1'b1;
                  end
                  tmi_pkg::ACT_RESUME: begin
                     steps_in = 16'd0;
                     state_in = ST_CHECK;
                     if (await_ff) begin
                        await_in = 1'b0;
                        tape_we  = 1'b1;
                        tape_wd  = req_input_eof ? tmi_pkg::EOF_BYTE : req_input_byte;
                        pos_in   = pos_ff + LW'(3);
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            tape_we = 1'b1;
            tape_wa = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == TW'(TAPE_DEPTH - 1)) begin
               clr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_CHECK: begin
            byte_in = 8'd0;
            if (pos_ff >= len_ff) begin
               kind_in  = tmi_pkg::KIND_HALTED;
               state_in = ST_EMIT;
            end else if (steps_ff >= budget_eff) begin
               kind_in  = tmi_pkg::KIND_BUDGET;
               state_in = ST_EMIT;
            end else begin
               steps_in = steps_ff + 1'b1;
               fp_in    = pos_ff;
               fk_in    = 3'd0;
               scan_in  = 1'b0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            fk_in = fk_ff + 1'b1;
            if (fk_ff == 3'(WIN_LEN_C)) begin
               state_in = scan_ff ? ST_SDEC : ST_DEC;
            end
         end
         ST_DEC: begin
            state_in = ST_CHECK;
            byte_in  = 8'd0;
            priority if (ge3 && w3 == tmi_pkg::TK_RIGHT) begin
               dp_in  = dp_next;
               pos_in = pos_ff + LW'(3);
            end else if (ge3 && w3 == tmi_pkg::TK_LEFT) begin
               dp_in  = dp_prev;
               pos_in = pos_ff + LW'(3);
            end else if (ge3 && w3 == tmi_pkg::TK_INC) begin
               tape_we = 1'b1;
               tape_wd = tape_q + 8'd1;
               pos_in  = pos_ff + LW'(3);
            end else if (ge3 && w3 == tmi_pkg::TK_DEC) begin
               tape_we = 1'b1;
               tape_wd = tape_q - 8'd1;
               pos_in  = pos_ff + LW'(3);
            end else if (ge6 && w6 == tmi_pkg::TK_OUT) begin
               pos_in   = pos_ff + LW'(6);
               kind_in  = tmi_pkg::KIND_OUTPUT;
               byte_in  = tape_q;
               state_in = ST_EMIT;
            end else if (ge3 && w3 == tmi_pkg::TK_IN) begin
               await_in = 1'b1;
               kind_in  = tmi_pkg::KIND_NEED_INPUT;
               state_in = ST_EMIT;
            end else if (ge3 && w3 == tmi_pkg::TK_OPEN) begin
               if (tape_q == 8'd0) begin
                  fp_in    = pos_ff + LW'(3);
                  depth_in = LW'(1);
                  state_in = ST_SCHK;
               end else if (sc_ff >= SCW'(STACK_DEPTH)) begin
                  kind_in  = tmi_pkg::KIND_OVERFLOW;
                  state_in = ST_EMIT;
               end else begin
                  stk_we = 1'b1;
                  sc_in  = sc_ff + 1'b1;
                  pos_in = pos_ff + LW'(3);
               end
            end else if (ge3 && w3 == tmi_pkg::TK_CLOSE) begin
               if (sc_ff == '0) begin
                  kind_in  = tmi_pkg::KIND_CLOSE_ERR;
                  state_in = ST_EMIT;
               end else if (tape_q != 8'd0) begin
                  pos_in = LW'(stk_q) + LW'(3);
               end else begin
                  sc_in  = sc_ff - 1'b1;
                  pos_in = pos_ff + LW'(3);
               end
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         ST_SCHK: begin
            if (depth_ff == '0) begin
               pos_in   = fp_ff;
               state_in = ST_CHECK;
            end else if (fp_ff >= len_ff) begin
               kind_in  = tmi_pkg::KIND_OPEN_ERR;
               byte_in  = 8'd0;
               state_in = ST_EMIT;
            end else begin
               fk_in    = 3'd0;
               scan_in  = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_SDEC: begin
            state_in = ST_SCHK;
            priority if (ge3 && w3 == tmi_pkg::TK_OPEN) begin
               depth_in = depth_ff + 1'b1;
               fp_in    = fp_ff + LW'(3);
            end else if (ge3 && w3 == tmi_pkg::TK_CLOSE) begin
               depth_in = depth_ff - 1'b1;
               fp_in    = fp_ff + LW'(3);
            end else begin
               fp_in = fp_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               clrpend_in = 1'b0;
               state_in   = clrpend_ff ? ST_CLEAR : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         len_ff       <= '0;
         pos_ff       <= '0;
         dp_ff        <= '0;
         clr_ff       <= '0;
         sc_ff        <= '0;
         await_ff     <= 1'b0;
         scan_ff      <= 1'b0;
         clrpend_ff   <= 1'b0;
         budget_ff    <= 16'hFFFF;
         steps_ff     <= 16'd0;
         fk_ff        <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         len_ff     <= len_in;
         pos_ff     <= pos_in;
         dp_ff      <= dp_in;
         clr_ff     <= clr_in;
         sc_ff      <= sc_in;
         await_ff   <= await_in;
         scan_ff    <= scan_in;
         clrpend_ff <= clrpend_in;
         steps_ff   <= steps_in;
         fk_ff      <= fk_in;
         if (csr_valid && csr_ready) begin
            budget_ff <= csr_step_budget;
         end
         if (state_ff == ST_EMIT && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      fp_ff    <= fp_in;
      depth_ff <= depth_in;
      kind_ff  <= kind_in;
      byte_ff  <= byte_in;
      if (state_ff == ST_EMIT && slot_free) begin
         rsp_kind_ff <= kind_ff;
         rsp_byte_ff <= byte_ff;
         rsp_pos_ff  <= 13'(pos_ff);
      end
   end

endmodule

// ===== test/tape_machine_interpreter_tb.sv =====
// Testbench for tape_machine_interpreter: drives programs and resumes through
// the req_/csr_ channels and checks each rsp_ transfer against a behavioral model.
// Depends on tmi_pkg and the tape_machine_interpreter RTL.
module tape_machine_interpreter_tb;

   localparam int unsigned PROG_DEPTH = 4096;
   localparam int unsigned CELLS      = 32768;
   localparam int unsigned LOOP_DEPTH = 64;
   localparam int unsigned WATCHDOG   = 20000000;
   localparam int unsigned HOLD_LEN   = 400;

   class tape_scoreboard;
      byte unsigned prog[PROG_DEPTH];
      byte unsigned cells[CELLS];
      int unsigned  loops[LOOP_DEPTH];
      int unsigned  plen, pos, dptr, depth, budget_reg;
      bit           waiting;
      tmi_pkg::kind_type kind_q[$];
      logic [7:0]   byte_q[$];
      logic [12:0]  pos_q[$];
      int           mismatches;

      function new();
         plen = 0;
         budget_reg = 65535;
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         pos = 0;
         dptr = 0;
         depth = 0;
         waiting = 0;
         foreach (cells[i]) cells[i] = 0;
      endfunction

      function bit at(int unsigned p, logic [47:0] tok, int n);
         if (p >= plen || plen - p < n) return 0;
         for (int i = 0; i < n; i++)
            if (prog[p + i] != tok[8*(n-1-i) +: 8]) return 0;
         return 1;
      endfunction

      function tmi_pkg::kind_type execute(output logic [7:0] ob);
         int unsigned lim, steps, d, q;
         lim = (budget_reg == 0) ? 1 : budget_reg;
         steps = 0;
         ob = 0;
         forever begin
            if (pos >= plen) return tmi_pkg::KIND_HALTED;
            if (steps >= lim) return tmi_pkg::KIND_BUDGET;
            steps++;
            if (at(pos, {24'd0, tmi_pkg::TK_RIGHT}, 3)) begin
               dptr = (dptr + 1) % CELLS;
               pos += 3;
            end else if (at(pos, {24'd0, tmi_pkg::TK_LEFT}, 3)) begin
               dptr = (dptr + CELLS - 1) % CELLS;
               pos += 3;
            end else if (at(pos, {24'd0, tmi_pkg::TK_INC}, 3)) begin
               cells[dptr]++;
               pos += 3;
            end else if (at(pos, {24'd0, tmi_pkg::TK_DEC}, 3)) begin
               cells[dptr]--;
               pos += 3;
            end else if (at(pos, tmi_pkg::TK_OUT, 6)) begin
               pos += 6;
               ob = cells[dptr];
               return tmi_pkg::KIND_OUTPUT;
            end else if (at(pos, {24'd0, tmi_pkg::TK_IN}, 3)) begin
               waiting = 1;
               return tmi_pkg::KIND_NEED_INPUT;
            end else if (at(pos, {24'd0, tmi_pkg::TK_OPEN}, 3)) begin
               if (cells[dptr] == 0) begin
                  d = 1;
                  q = pos + 3;
                  while (d > 0 && q < plen) begin
                     if (at(q, {24'd0, tmi_pkg::TK_OPEN}, 3)) begin
                        d++;
                        q += 3;
                     end else if (at(q, {24'd0, tmi_pkg::TK_CLOSE}, 3)) begin
                        d--;
                        q += 3;
                     end else q++;
                  end
                  if (d != 0) return tmi_pkg::KIND_OPEN_ERR;
                  pos = q;
               end else begin
                  if (depth >= LOOP_DEPTH) return tmi_pkg::KIND_OVERFLOW;
                  loops[depth++] = pos;
                  pos += 3;
               end
            end else if (at(pos, {24'd0, tmi_pkg::TK_CLOSE}, 3)) begin
               if (depth == 0) return tmi_pkg::KIND_CLOSE_ERR;
               if (cells[dptr] != 0) pos = loops[depth-1] + 3;
               else begin
                  depth--;
                  pos += 3;
               end
            end else pos++;
         end
      endfunction

      function tmi_pkg::kind_type note(tmi_pkg::action_type a, logic [7:0] pb,
                                       logic [7:0] ib, logic eof);
         tmi_pkg::kind_type k;
         logic [7:0] ob;
         ob = 0;
         case (a)
            tmi_pkg::ACT_APPEND: begin
               if (plen >= PROG_DEPTH) k = tmi_pkg::KIND_FULL;
               else begin
                  prog[plen++] = pb;
                  k = tmi_pkg::KIND_ACK;
               end
            end
            tmi_pkg::ACT_CLEAR: begin
               plen = 0;
               restart();
               k = tmi_pkg::KIND_ACK;
            end
            tmi_pkg::ACT_RESTART: begin
               restart();
               k = tmi_pkg::KIND_ACK;
            end
            default: begin
               if (waiting) begin
                  waiting = 0;
                  cells[dptr] = eof ? tmi_pkg::EOF_BYTE : ib;
                  pos += 3;
               end
               k = execute(ob);
            end
         endcase
         kind_q.insert(kind_q.size(), k);
         byte_q.insert(byte_q.size(), ob);
         pos_q.insert(pos_q.size(), pos[12:0]);
         return k;
      endfunction

      function void check(logic [3:0] k, logic [7:0] b, logic [12:0] p);
         if (kind_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: kind %0d byte %0d pos %0d", k, b, p);
            return;
         end
         if (k !== kind_q[0] || b !== byte_q[0] || p !== pos_q[0]) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp kind %0d byte %0d pos %0d, got kind %0d byte %0d pos %0d",
                        kind_q[0], byte_q[0], pos_q[0], k, b, p);
         end
         void'(kind_q.pop_front());
         void'(byte_q.pop_front());
         void'(pos_q.pop_front());
      endfunction

      function int pending();
         return kind_q.size();
      endfunction
   endclass

   logic        clock, reset;
   logic        req_valid, req_ready, req_input_eof;
   logic [1:0]  req_action;
   logic [7:0]  req_program_byte, req_input_byte;
   logic        rsp_valid, rsp_ready;
   logic [3:0]  rsp_kind;
   logic [7:0]  rsp_out_byte;
   logic [12:0] rsp_program_position;
   logic        csr_valid, csr_ready;
   logic [15:0] csr_step_budget;

   tape_scoreboard sb;
   int unsigned    send_idle, recv_stall, hold_cnt, idle_cycles;
   bit             start_hold;
   tmi_pkg::kind_type last_kind;

   tape_machine_interpreter uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_program_byte(req_program_byte), .req_input_byte(req_input_byte),
      .req_input_eof(req_input_eof),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_out_byte(rsp_out_byte), .rsp_program_position(rsp_program_position),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_step_budget(csr_step_budget)
   );

   always begin
      clock = 1;
      #5;
      clock = 0;
      #5;
   end

   // receiver: random stalls plus a long hold-off on request
   always @(negedge clock) begin
      if (start_hold) begin
         start_hold = 0;
         hold_cnt = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_ready = 0;
      end else rsp_ready = ($urandom_range(99) >= recv_stall);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check(rsp_kind, rsp_out_byte, rsp_program_position);
   end

   always @(posedge clock) begin
      if (reset) idle_cycles = 0;
      else if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
               (csr_valid && csr_ready)) idle_cycles = 0;
      else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic send(tmi_pkg::action_type a, logic [7:0] pb = 0, logic [7:0] ib = 0,
                       logic eof = 0);
      while ($urandom_range(99) < send_idle) @(negedge clock);
      req_valid = 1;
      req_action = a;
      req_program_byte = pb;
      req_input_byte = ib;
      req_input_eof = eof;
      do @(posedge clock); while (!req_ready);
      last_kind = sb.note(a, pb, ib, eof);
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic put_token(logic [47:0] tok, int n);
      for (int i = 0; i < n; i++) send(tmi_pkg::ACT_APPEND, tok[8*(n-1-i) +: 8]);
   endtask

   task automatic set_budget(logic [15:0] v);
      while (sb.pending() != 0) @(negedge clock);
      csr_valid = 1;
      csr_step_budget = v;
      do @(posedge clock); while (!csr_ready);
      sb.budget_reg = v;
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic resume();
      send(tmi_pkg::ACT_RESUME, 8'h00, 8'($urandom_range(255)), $urandom_range(3) == 0);
   endtask

   // random token stream, mostly balanced brackets, some noise bytes
   task automatic random_program(int ntok);
      int opens, sel;
      opens = 0;
      for (int i = 0; i < ntok; i++) begin
         sel = $urandom_range(11);
         case (sel)
            0: put_token({24'd0, tmi_pkg::TK_RIGHT}, 3);
            1: put_token({24'd0, tmi_pkg::TK_LEFT}, 3);
            2, 3: put_token({24'd0, tmi_pkg::TK_INC}, 3);
            4: put_token({24'd0, tmi_pkg::TK_DEC}, 3);
            5: put_token(tmi_pkg::TK_OUT, 6);
            6: put_token({24'd0, tmi_pkg::TK_IN}, 3);
            7: begin
               put_token({24'd0, tmi_pkg::TK_OPEN}, 3);
               opens++;
            end
            8: if (opens > 0 || $urandom_range(30) == 0) begin
               put_token({24'd0, tmi_pkg::TK_CLOSE}, 3);
               if (opens > 0) opens--;
            end
            9: put_token(tmi_pkg::TK_OUT, $urandom_range(1, 5));
            default: send(tmi_pkg::ACT_APPEND, 8'($urandom_range(255)));
         endcase
      end
      if ($urandom_range(9) != 0)
         while (opens > 0) begin
            put_token({24'd0, tmi_pkg::TK_CLOSE}, 3);
            opens--;
         end
   endtask

   initial begin
      sb = new();
      reset = 1;
      req_valid = 0;
      req_action = tmi_pkg::ACT_APPEND;
      req_program_byte = 0;
      req_input_byte = 0;
      req_input_eof = 0;
      csr_valid = 0;
      csr_step_budget = 0;
      rsp_ready = 0;
      start_hold = 0;
      hold_cnt = 0;
      send_idle = 0;
      recv_stall = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed
      resume();
      set_budget(0);
      put_token({24'd0, tmi_pkg::TK_INC}, 3);
      put_token({24'd0, tmi_pkg::TK_INC}, 3);
      put_token(tmi_pkg::TK_OUT, 6);
      resume();
      resume();
      set_budget(65535);
      resume();
      put_token({24'd0, tmi_pkg::TK_IN}, 3);
      put_token(tmi_pkg::TK_OUT, 6);
      resume();
      send(tmi_pkg::ACT_RESUME, 8'h00, 8'h5A, 1);
      put_token({24'd0, tmi_pkg::TK_IN}, 3);
      put_token(tmi_pkg::TK_OUT, 6);
      resume();
      send(tmi_pkg::ACT_RESUME, 8'h00, 8'hA5, 0);
      put_token({24'd0, tmi_pkg::TK_LEFT}, 3);
      put_token({24'd0, tmi_pkg::TK_DEC}, 3);
      put_token(tmi_pkg::TK_OUT, 6);
      resume();
      resume();
      send(tmi_pkg::ACT_CLEAR);
      put_token({24'd0, tmi_pkg::TK_CLOSE}, 3);
      resume();
      resume();
      send(tmi_pkg::ACT_CLEAR);
      put_token({24'd0, tmi_pkg::TK_OPEN}, 3);
      resume();
      send(tmi_pkg::ACT_CLEAR);
      set_budget(200);
      put_token({24'd0, tmi_pkg::TK_INC}, 3);
      for (int i = 0; i <= LOOP_DEPTH; i++) put_token({24'd0, tmi_pkg::TK_OPEN}, 3);
      resume();
      resume();
      send(tmi_pkg::ACT_CLEAR);

      // random
      for (int r = 0; r < 20; r++) begin
         case (r % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 52; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 52; end
            default: begin send_idle = 34; recv_stall = 34; end
         endcase
         if (r == 0 || $urandom_range(2) == 0)
            set_budget(16'($urandom_range(3) == 0 ? $urandom_range(1)
                                                  : $urandom_range(2, 400)));
         if (sb.plen > 3000) send(tmi_pkg::ACT_CLEAR);
         if (r == 6) start_hold = 1;
         random_program($urandom_range(4, 25));
         for (int j = 0; j < 10; j++) begin
            resume();
            if (last_kind == tmi_pkg::KIND_HALTED ||
                (last_kind >= tmi_pkg::KIND_OPEN_ERR && last_kind != tmi_pkg::KIND_BUDGET))
               break;
         end
         if (last_kind != tmi_pkg::KIND_HALTED || r % 6 == 5) begin
            if ($urandom_range(1) == 0) resume();
            send($urandom_range(1) ? tmi_pkg::ACT_RESTART : tmi_pkg::ACT_CLEAR);
         end
      end

      while (sb.pending() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (sb.mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
